/* hw/rtl/u2rgb_pkg.sv */
// Shared types and constants for the UYVY to RGB converter.
// No dependencies; imported by every module of the block.
package u2rgb_pkg;

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int MAX_RATIO      = 64;

    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W   = 12;
    localparam int PHASE_W = 6;
    localparam int RATIO_W = 7;
    localparam int PROD_W  = 25;
    localparam int Q_SHIFT = 14;
    localparam int OFF_W   = PROD_W - Q_SHIFT;

    localparam logic signed [16:0] K_RED_V   = 17'sd18678;
    localparam logic signed [16:0] K_GREEN_V = -17'sd9519;
    localparam logic signed [16:0] K_GREEN_U = 17'sd6472;
    localparam logic signed [16:0] K_BLUE_U  = 17'sd33292;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(8192);
    localparam logic [7:0] BYTE_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_HORIZ_RATIO  = 2'd2,
        REG_VERT_RATIO   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] red;
        logic signed [PROD_W-1:0] green;
        logic signed [PROD_W-1:0] blue;
    } chroma_t;

    typedef struct packed {
        logic emit;
        logic two;
        logic eol;
        logic eof;
    } meta_t;

endpackage

/* hw/rtl/u2rgb_chroma.sv */
// Chroma products: centers u and v and forms the Q14 red, green and blue terms.
// Depends on u2rgb_pkg.
module u2rgb_chroma (
    input  logic [7:0]        chroma_u,
    input  logic [7:0]        chroma_v,
    output u2rgb_pkg::chroma_t prod
);
    import u2rgb_pkg::*;

    logic signed [7:0]        u_c;
    logic signed [7:0]        v_c;
    logic signed [PROD_W-1:0] u_ext;
    logic signed [PROD_W-1:0] v_ext;

    // x - 128 is the byte with its top bit flipped, read as signed
    assign u_c   = {~chroma_u[7], chroma_u[6:0]};
    assign v_c   = {~chroma_v[7], chroma_v[6:0]};
    assign u_ext = PROD_W'(u_c);
    assign v_ext = PROD_W'(v_c);

    assign prod.red   = v_ext * K_RED_V;
    assign prod.green = v_ext * K_GREEN_V - u_ext * K_GREEN_U;
    assign prod.blue  = u_ext * K_BLUE_U;

endmodule

/* hw/rtl/u2rgb_lane.sv */
// One pixel lane: rounds the chroma terms, adds luma and clamps each channel.
// Depends on u2rgb_pkg.
module u2rgb_lane (
    input  u2rgb_pkg::chroma_t prod,
    input  logic [7:0]         luma,
    output u2rgb_pkg::pixel_t  pixel
);
    import u2rgb_pkg::*;

    function automatic logic [7:0] add_clamp(logic signed [PROD_W-1:0] p, logic [7:0] y);
        logic signed [PROD_W-1:0] biased;
        logic signed [OFF_W-1:0]  off;
        logic signed [OFF_W:0]    sum;
        biased = p + ROUND_BIAS;
        off    = OFF_W'(biased >>> Q_SHIFT);
        sum    = (OFF_W + 1)'(off) + $signed({(OFF_W - 7)'(0), y});
        if (sum < 0)
            return 8'd0;
        else if (sum > $signed({(OFF_W - 7)'(0), BYTE_MAX}))
            return BYTE_MAX;
        else
            return sum[7:0];
    endfunction

    assign pixel.red   = add_clamp(prod.red, luma);
    assign pixel.green = add_clamp(prod.green, luma);
    assign pixel.blue  = add_clamp(prod.blue, luma);

endmodule

/* hw/rtl/u2rgb_ctrl.sv */
// Register file and position tracking: column, line and decimation phases.
// Depends on u2rgb_pkg.
module u2rgb_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [u2rgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [u2rgb_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                           accept,
    output u2rgb_pkg::meta_t               meta
);
    import u2rgb_pkg::*;

    // registers hold the sanitized values
    logic [CFG_W-1:0]   lw_reg, lw_next;
    logic [CFG_W-1:0]   fh_reg, fh_next;
    logic [PHASE_W-1:0] gp_reg, gp_next;
    logic               h_one_reg, h_one_next;
    logic [RATIO_W-1:0] vr_reg, vr_next;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [COL_W-1:0]   line_reg, line_next;
    logic [PHASE_W-1:0] cph_reg, cph_next;
    logic [PHASE_W-1:0] lph_reg, lph_next;

    logic [CFG_W-1:0]   wd_even;
    logic [RATIO_W-1:0] wd_ratio;
    logic               full;
    logic               line_done;
    logic               frame_done;
    logic               eol_dec;
    logic               eof_dec;

    assign wd_even  = {cfg_wdata[CFG_W-1:1], 1'b0};
    assign wd_ratio = cfg_wdata[RATIO_W-1:0];

    always_comb
    begin
        lw_next    = lw_reg;
        fh_next    = fh_reg;
        gp_next    = gp_reg;
        h_one_next = h_one_reg;
        vr_next    = vr_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LINE_WIDTH:
                begin
                    if (wd_even > CFG_W'(MAX_LINE_WIDTH))
                        lw_next = CFG_W'(MAX_LINE_WIDTH);
                    else if (wd_even < CFG_W'(2))
                        lw_next = CFG_W'(2);
                    else
                        lw_next = wd_even;
                end
                REG_FRAME_HEIGHT:
                begin
                    if (cfg_wdata > CFG_W'(MAX_LINE_WIDTH))
                        fh_next = CFG_W'(MAX_LINE_WIDTH);
                    else if (cfg_wdata == '0)
                        fh_next = CFG_W'(1);
                    else
                        fh_next = cfg_wdata;
                end
                REG_HORIZ_RATIO:
                begin
                    h_one_next = (wd_ratio <= RATIO_W'(1));
                    if (wd_ratio > RATIO_W'(MAX_RATIO))
                        gp_next = PHASE_W'(MAX_RATIO / 2);
                    else if (wd_ratio < RATIO_W'(4))
                        gp_next = PHASE_W'(1);
                    else
                        gp_next = wd_ratio[PHASE_W:1];
                end
                REG_VERT_RATIO:
                begin
                    if (wd_ratio > RATIO_W'(MAX_RATIO))
                        vr_next = RATIO_W'(MAX_RATIO);
                    else if (wd_ratio == '0)
                        vr_next = RATIO_W'(1);
                    else
                        vr_next = wd_ratio;
                end
                default: ;
            endcase
        end
    end

    assign full       = h_one_reg && (vr_reg == RATIO_W'(1));
    assign line_done  = ({2'b0, col_reg} + 14'd2) >= {1'b0, lw_reg};
    assign frame_done = ({1'b0, line_reg} + 13'd1) >= fh_reg;
    assign eol_dec    = ({2'b0, col_reg} + {7'b0, gp_reg, 1'b0}) >= {1'b0, lw_reg};
    assign eof_dec    = eol_dec && (({1'b0, line_reg} + {6'b0, vr_reg}) >= fh_reg);

    always_comb
    begin
        meta.two  = full;
        meta.emit = full || ((cph_reg == '0) && (lph_reg == '0));
        meta.eol  = full ? line_done : eol_dec;
        meta.eof  = full ? (line_done && frame_done) : eof_dec;
    end

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        cph_next  = cph_reg;
        lph_next  = lph_reg;
        if (accept)
        begin
            if (line_done)
            begin
                col_next = '0;
                cph_next = '0;
                if (frame_done)
                begin
                    line_next = '0;
                    lph_next  = '0;
                end
                else
                begin
                    line_next = line_reg + COL_W'(1);
                    lph_next  = (({1'b0, lph_reg} + 7'd1) >= vr_reg) ? '0 : lph_reg + 6'd1;
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(2);
                cph_next = (({1'b0, cph_reg} + 7'd1) >= {1'b0, gp_reg}) ? '0 : cph_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg    <= CFG_W'(640);
            fh_reg    <= CFG_W'(480);
            gp_reg    <= PHASE_W'(1);
            h_one_reg <= 1'b1;
            vr_reg    <= RATIO_W'(1);
            col_reg   <= '0;
            line_reg  <= '0;
            cph_reg   <= '0;
            lph_reg   <= '0;
        end
        else
        begin
            lw_reg    <= lw_next;
            fh_reg    <= fh_next;
            gp_reg    <= gp_next;
            h_one_reg <= h_one_next;
            vr_reg    <= vr_next;
            col_reg   <= col_next;
            line_reg  <= line_next;
            cph_reg   <= cph_next;
            lph_reg   <= lph_next;
        end
    end

endmodule

/* hw/rtl/u2rgb_merge.sv */
// Output stage: merges the two lane pixels into one result register.
// Depends on u2rgb_pkg.
module u2rgb_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  u2rgb_pkg::pixel_t pix_first,
    input  u2rgb_pkg::pixel_t pix_second,
    input  u2rgb_pkg::meta_t  meta,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic              m_tlast,
    output logic [2:0]        m_tuser
);
    import u2rgb_pkg::*;

    logic       valid_reg;
    logic [47:0] data_reg, data_next;
    logic       last_reg;
    logic [2:0] user_reg, user_next;

    assign in_ready = !valid_reg || m_tready;

    // second pixel reads as zero when only one is produced
    always_comb
    begin
        data_next = {pix_first.red, pix_first.green, pix_first.blue,
                     pix_second.red, pix_second.green, pix_second.blue};
        data_next = {data_next[47:24], meta.two ? data_next[23:0] : 24'd0};
        // reorder: red in the lowest byte
        data_next = {data_next[7:0], data_next[15:8], data_next[23:16],
                     data_next[31:24], data_next[39:32], data_next[47:40]};
        user_next = {meta.eof, meta.two ? 2'd2 : 2'd1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
            last_reg <= meta.eol;
            user_reg <= user_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

/* hw/rtl/uyvy_to_rgb_converter.sv */
// UYVY to RGB888 converter top level: chroma stage, two pixel lanes, merge stage.
// Depends on u2rgb_pkg, u2rgb_ctrl, u2rgb_chroma, u2rgb_lane, u2rgb_merge.
//
// Takes one UYVY group per request and sustains one group per clock unless the
// output stalls. From acceptance to m_tvalid the chroma products are registered,
// then two lanes round, add luma and clamp in parallel into the output register.
// At full resolution each result carries two pixels; with decimation only
// groups on kept columns and rows produce a result, and the others are
// consumed with no output. m_tlast marks the end of an output line.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while idle.
module uyvy_to_rgb_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [u2rgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [u2rgb_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // chroma_u, luma_first, chroma_v, luma_second
    input  logic [31:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_first, green_first, blue_first, red_second, green_second, blue_second
    output logic [47:0]                     m_tdata,
    output logic                            m_tlast,
    // pixel_count[1:0], end_of_frame
    output logic [2:0]                      m_tuser
);
    import u2rgb_pkg::*;

    logic    accept;
    meta_t   meta;
    chroma_t prod;
    logic    merge_ready;
    pixel_t  pix_first;
    pixel_t  pix_second;

    logic       s1_valid_reg;
    chroma_t    s1_prod_reg;
    logic [7:0] s1_y0_reg;
    logic [7:0] s1_y1_reg;
    meta_t      s1_meta_reg;

    assign s_tready = !s1_valid_reg || merge_ready;
    assign accept   = s_tvalid && s_tready;

    u2rgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .meta      (meta)
    );

    u2rgb_chroma u_chroma (
        .chroma_u (s_tdata[7:0]),
        .chroma_v (s_tdata[23:16]),
        .prod     (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid && meta.emit;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prod_reg <= prod;
            s1_y0_reg   <= s_tdata[15:8];
            s1_y1_reg   <= s_tdata[31:24];
            s1_meta_reg <= meta;
        end
    end

    u2rgb_lane u_lane_first (
        .prod  (s1_prod_reg),
        .luma  (s1_y0_reg),
        .pixel (pix_first)
    );

    u2rgb_lane u_lane_second (
        .prod  (s1_prod_reg),
        .luma  (s1_y1_reg),
        .pixel (pix_second)
    );

    u2rgb_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_ready   (merge_ready),
        .pix_first  (pix_first),
        .pix_second (pix_second),
        .meta       (s1_meta_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

/* dv/u2rgb_checker.sv */
// Scoreboard for uyvy_to_rgb_converter: tracks register writes, predicts RGB results
// for accepted UYVY groups that yield one and compares them with the output stream.
// Depends on u2rgb_pkg.
module u2rgb_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [u2rgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [u2rgb_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [31:0]                     s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [47:0]                     m_tdata,
    input  logic                            m_tlast,
    input  logic [2:0]                      m_tuser,
    output int                              errors,
    output int                              pending
);
    import u2rgb_pkg::*;

    typedef struct packed {
        pixel_t     first;
        pixel_t     second;
        logic [1:0] count;
        logic       eol;
        logic       eof;
    } rgb_result_t;

    rgb_result_t expected_pixels[$];
    int          mismatches;

    logic [CFG_W-1:0]   line_width;
    logic [CFG_W-1:0]   frame_height;
    logic [RATIO_W-1:0] horiz_ratio;
    logic [RATIO_W-1:0] vert_ratio;
    logic [COL_W-1:0]   pixel_column;
    logic [COL_W-1:0]   line_index;
    logic [PHASE_W-1:0] column_phase;
    logic [PHASE_W-1:0] line_phase;

    // luma plus Q14 offset rounded half up with floor, then clamped to a byte
    function automatic logic [7:0] clamp_channel(input int luma, input int product);
        int level;
        level = luma + ((product + int'(ROUND_BIAS)) >>> Q_SHIFT);
        if (level < 0)
            return 8'd0;
        if (level > 255)
            return BYTE_MAX;
        return level[7:0];
    endfunction

    function automatic pixel_t to_rgb(input int luma, input int u, input int v);
        pixel_t p;
        p.red   = clamp_channel(luma, v * K_RED_V);
        p.green = clamp_channel(luma, v * K_GREEN_V - u * K_GREEN_U);
        p.blue  = clamp_channel(luma, u * K_BLUE_U);
        return p;
    endfunction

    function automatic int eff_ratio(input logic [RATIO_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_RATIO)
            return MAX_RATIO;
        return int'(r);
    endfunction

    task automatic convert_group(input logic [31:0] grp);
        int          lw;
        int          fh;
        int          hr;
        int          vr;
        int          gp;
        int          u;
        int          v;
        bit          full;
        rgb_result_t r;
        lw = int'(line_width) & ~1;
        if (lw > MAX_LINE_WIDTH)
            lw = MAX_LINE_WIDTH;
        if (lw < 2)
            lw = 2;
        fh = int'(frame_height);
        if (fh > MAX_LINE_WIDTH)
            fh = MAX_LINE_WIDTH;
        if (fh < 1)
            fh = 1;
        hr = eff_ratio(horiz_ratio);
        vr = eff_ratio(vert_ratio);
        gp = hr >> 1;
        if (gp == 0)
            gp = 1;
        full = (hr == 1) && (vr == 1);
        u = int'(grp[7:0]) - 128;
        v = int'(grp[23:16]) - 128;
        r = '0;

        if (full)
        begin
            r.first  = to_rgb(int'(grp[15:8]), u, v);
            r.second = to_rgb(int'(grp[31:24]), u, v);
            r.count  = 2'd2;
            r.eol    = (int'(pixel_column) + 2 >= lw);
            r.eof    = r.eol && (int'(line_index) + 1 >= fh);
            expected_pixels.push_back(r);
        end
        else if (column_phase == 0 && line_phase == 0)
        begin
            r.first = to_rgb(int'(grp[15:8]), u, v);
            r.count = 2'd1;
            // flags look ahead to the next kept column / row
            r.eol   = (int'(pixel_column) + 2 * gp >= lw);
            r.eof   = r.eol && (int'(line_index) + vr >= fh);
            expected_pixels.push_back(r);
        end

        if (int'(pixel_column) + 2 >= lw)
        begin
            pixel_column = '0;
            column_phase = '0;
            if (int'(line_index) + 1 >= fh)
            begin
                line_index = '0;
                line_phase = '0;
            end
            else
            begin
                line_index = line_index + 1'b1;
                line_phase = (int'(line_phase) + 1 >= vr) ? '0 : line_phase + 1'b1;
            end
        end
        else
        begin
            pixel_column = pixel_column + 2'd2;
            column_phase = (int'(column_phase) + 1 >= gp) ? '0 : column_phase + 1'b1;
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgb_result_t want;
        if (!rst_n)
        begin
            line_width   = 13'd640;
            frame_height = 13'd480;
            horiz_ratio  = 7'd1;
            vert_ratio   = 7'd1;
            pixel_column = '0;
            line_index   = '0;
            column_phase = '0;
            line_phase   = '0;
            mismatches   = 0;
            expected_pixels.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_LINE_WIDTH:   line_width   = cfg_wdata;
                    REG_FRAME_HEIGHT: frame_height = cfg_wdata;
                    REG_HORIZ_RATIO:  horiz_ratio  = cfg_wdata[RATIO_W-1:0];
                    REG_VERT_RATIO:   vert_ratio   = cfg_wdata[RATIO_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                convert_group(s_tdata);

            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected, data %h", $time, m_tdata);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red_first",    want.first.red,    m_tdata[7:0]);
                    check_field("green_first",  want.first.green,  m_tdata[15:8]);
                    check_field("blue_first",   want.first.blue,   m_tdata[23:16]);
                    check_field("red_second",   want.second.red,   m_tdata[31:24]);
                    check_field("green_second", want.second.green, m_tdata[39:32]);
                    check_field("blue_second",  want.second.blue,  m_tdata[47:40]);
                    check_field("pixel_count",  want.count,        m_tuser[1:0]);
                    check_field("end_of_line",  want.eol,          m_tlast);
                    check_field("end_of_frame", want.eof,          m_tuser[2]);
                end
            end

            errors  <= mismatches;
            pending <= expected_pixels.size();
        end
    end

endmodule

/* dv/tb_top.sv */
// Testbench top for uyvy_to_rgb_converter: clock, reset, register phases and
// UYVY request traffic with random idle and stall patterns.
// Depends on u2rgb_pkg, the converter RTL and u2rgb_checker.
module tb_top;
    import u2rgb_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 4;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_wr_en = 1'b0;
    cfg_reg_t           cfg_index = REG_LINE_WIDTH;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [47:0]        m_tdata;
    logic               m_tlast;
    logic [2:0]         m_tuser;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int errors;
    int pending;

    // {luma_second, chroma_v, luma_first, chroma_u}
    logic [31:0] directed_groups [12] = '{
        32'h00000000, 32'hFFFFFFFF, 32'h80808080, 32'h00FF00FF,
        32'hFF00FF00, 32'hFFFF0000, 32'h0000FFFF, 32'hEB80EB80,
        32'h10801080, 32'h00FFFF00, 32'hFF0000FF, 32'h55AA55AA
    };

    uyvy_to_rgb_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    u2rgb_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // bytes lean toward 0x00 and 0xFF to hit the clamps
    function automatic logic [31:0] random_group();
        logic [31:0] grp;
        int          b;
        for (b = 0; b < 4; b++)
        begin
            case ($urandom_range(7))
                0:       grp[8*b +: 8] = 8'h00;
                1:       grp[8*b +: 8] = 8'hFF;
                default: grp[8*b +: 8] = 8'($urandom);
            endcase
        end
        return grp;
    endfunction

    task automatic send_group(input logic [31:0] grp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= grp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // pending is registered in the checker, hence the first wait
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
    endtask

    task automatic run_phase(input int lw, input int fh, input int hr, input int vr,
                             input int groups, input int idle_pct, input int stall_pct,
                             input bit hold_mid);
        int i;
        wait_drained();
        // dropped groups may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_LINE_WIDTH, lw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_HORIZ_RATIO, hr);
        write_reg(REG_VERT_RATIO, vr);
        cfg_wr_en      <= 1'b0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < groups; i++)
        begin
            if (hold_mid && i == groups / 2)
                wait_drained();
            send_group(random_group());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: full resolution, clamp extremes
        foreach (directed_groups[i])
            send_group(directed_groups[i]);

        run_phase(8,    4,    1,   1,   80,  0,  0,  1'b0);
        run_phase(2,    1,    1,   1,   40,  74, 0,  1'b0);
        run_phase(6,    3,    2,   2,   100, 0,  74, 1'b1);
        run_phase(16,   8,    4,   2,   80,  34, 34, 1'b0);
        // horizontal 1 with vertical decimation
        run_phase(10,   6,    1,   4,   80,  74, 0,  1'b0);
        // an odd horizontal ratio floors the column period
        run_phase(12,   5,    3,   5,   80,  0,  74, 1'b0);
        run_phase(2,    1,    64,  64,  40,  34, 34, 1'b0);
        run_phase(4096, 4096, 1,   1,   60,  0,  0,  1'b0);
        // odd width, zero height and zero ratios
        run_phase(7,    0,    0,   0,   60,  34, 34, 1'b0);
        // out-of-range values saturate
        run_phase(8191, 8191, 127, 127, 40,  74, 0,  1'b0);
        run_phase(2,    130,  2,   64,  100, 0,  0,  1'b0);
        run_phase(20,   7,    2,   1,   80,  34, 34, 1'b1);

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
